/* hw/rtl/lsr_pkg.sv */
// Shared constants, codes and types of the line segment rasterizer.
package lsr_pkg;

   localparam int COORD_BITS  = 16;
   localparam int IMG_WIDTH   = 1024;
   localparam int IMG_HEIGHT  = 1024;

   localparam int DELTA_BITS  = COORD_BITS + 1;
   localparam int INC_S_BITS  = COORD_BITS + 2;
   localparam int ERR_BITS    = COORD_BITS + 3;
   localparam int Y_BITS      = (IMG_HEIGHT > 1) ? $clog2(IMG_HEIGHT) : 1;

   localparam int PITCH_BITS  = 13;
   localparam int ADDR_BITS   = 24;
   localparam int PADDR_BITS  = 3;
   localparam int PDATA_BITS  = 32;
   localparam logic [PITCH_BITS-1:0] PITCH_RESET = 13'd1024;

   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
   localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

   // Request codes.
   localparam logic REQ_LOAD    = 1'b0;
   localparam logic REQ_ADVANCE = 1'b1;

   // Register index taken from paddr above the byte offset.
   localparam logic REG_PITCH = 1'b0;

   typedef struct packed {
      logic                          req_type;
      logic signed [COORD_BITS-1:0]  start_x;
      logic signed [COORD_BITS-1:0]  start_y;
      logic signed [COORD_BITS-1:0]  end_x;
      logic signed [COORD_BITS-1:0]  end_y;
   } req_data_type;

   typedef struct packed {
      logic signed [COORD_BITS-1:0]  pixel_x;
      logic signed [COORD_BITS-1:0]  pixel_y;
      logic [ADDR_BITS-1:0]          pixel_addr;
      logic                          pixel_inside;
      logic                          last_pixel;
   } rsp_data_type;

   // Command passed from the front to the back through the queue.
   typedef struct packed {
      logic                    is_load;
      logic [COORD_BITS-1:0]   cur_major;
      logic [COORD_BITS-1:0]   cur_minor;
      logic [ERR_BITS-1:0]     error_term;
      logic [INC_S_BITS-1:0]   inc_straight;
      logic [ERR_BITS-1:0]     inc_diagonal;
      logic [DELTA_BITS-1:0]   pixels_left;
      logic                    major_step_neg;
      logic                    minor_step_neg;
      logic                    major_is_x;
   } cmd_type;

endpackage

/* hw/rtl/lsr_front.sv */
// Front end: accepts request beats and turns each into a queue command, with Bresenham setup for loads.
module lsr_front import lsr_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_stall,
   input  req_data_type  req_data,
   output logic          push,
   output cmd_type       push_cmd,
   input  logic          queue_full
);

   typedef struct packed {
      logic                    is_load;
      logic [DELTA_BITS-1:0]   dx;
      logic [DELTA_BITS-1:0]   dy;
      logic                    x_neg;
      logic                    y_neg;
      logic [COORD_BITS-1:0]   x0;
      logic [COORD_BITS-1:0]   y0;
   } front_stage_type;

   logic             s1_valid_ff, s1_valid_in;
   front_stage_type  s1_ff, s1_in;
   logic             s1_take;

   logic [DELTA_BITS-1:0] dx_diff, dy_diff;

   logic                    major_x;
   logic [DELTA_BITS-1:0]   dmaj, dmin;
   logic [COORD_BITS-1:0]   smaj, smin;
   logic                    maj_neg, min_neg;
   logic [INC_S_BITS-1:0]   dmin_diff;

   assign req_stall = s1_valid_ff && queue_full;
   assign push      = s1_valid_ff && !queue_full;
   assign s1_take   = !s1_valid_ff || !queue_full;

   // Signed deltas and their magnitudes.
   always_comb begin
      dx_diff = {req_data.end_x[COORD_BITS-1], req_data.end_x}
              - {req_data.start_x[COORD_BITS-1], req_data.start_x};
      dy_diff = {req_data.end_y[COORD_BITS-1], req_data.end_y}
              - {req_data.start_y[COORD_BITS-1], req_data.start_y};
      s1_in.is_load = (req_data.req_type == REQ_LOAD);
      s1_in.x_neg   = dx_diff[DELTA_BITS-1];
      s1_in.y_neg   = dy_diff[DELTA_BITS-1];
      s1_in.dx      = dx_diff[DELTA_BITS-1] ? (~dx_diff + DELTA_BITS'(1)) : dx_diff;
      s1_in.dy      = dy_diff[DELTA_BITS-1] ? (~dy_diff + DELTA_BITS'(1)) : dy_diff;
      s1_in.x0      = req_data.start_x;
      s1_in.y0      = req_data.start_y;
      s1_valid_in   = s1_take ? req_valid : s1_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
      if (s1_take && req_valid) begin
         s1_ff <= s1_in;
      end
   end

   // Major axis choice, ties going to x, and the initial error terms.
   always_comb begin
      major_x = (s1_ff.dy <= s1_ff.dx);
      dmaj    = major_x ? s1_ff.dx : s1_ff.dy;
      dmin    = major_x ? s1_ff.dy : s1_ff.dx;
      smaj    = major_x ? s1_ff.x0 : s1_ff.y0;
      smin    = major_x ? s1_ff.y0 : s1_ff.x0;
      maj_neg = major_x ? s1_ff.x_neg : s1_ff.y_neg;
      min_neg = major_x ? s1_ff.y_neg : s1_ff.x_neg;
      dmin_diff = {1'b0, dmin} - {1'b0, dmaj};

      push_cmd.is_load        = s1_ff.is_load;
      push_cmd.cur_major      = maj_neg ? (smaj - COORD_BITS'(1)) : (smaj + COORD_BITS'(1));
      push_cmd.cur_minor      = smin;
      push_cmd.inc_straight   = {dmin, 1'b0};
      push_cmd.inc_diagonal   = {dmin_diff, 1'b0};
      push_cmd.error_term     = {1'b0, dmin, 1'b0} - {2'b00, dmaj};
      push_cmd.pixels_left    = (dmaj > DELTA_BITS'(1)) ? (dmaj - DELTA_BITS'(1)) : '0;
      push_cmd.major_step_neg = maj_neg;
      push_cmd.minor_step_neg = min_neg;
      push_cmd.major_is_x     = major_x;
   end

endmodule

/* hw/rtl/lsr_queue.sv */
// Short command queue between the front end and the stepping back end.
module lsr_queue import lsr_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   input  cmd_type  push_cmd,
   output logic     full,
   input  logic     pop,
   output logic     head_valid,
   output cmd_type  head_cmd
);

   cmd_type               entry_ff [QUEUE_DEPTH];
   logic [QPTR_BITS-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [QPTR_BITS-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [QCNT_BITS-1:0]  count_ff, count_in;

   assign full       = (count_ff == QCNT_BITS'(QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_cmd   = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? (wr_ptr_ff + QPTR_BITS'(1)) : wr_ptr_ff;
      rd_ptr_in = pop  ? (rd_ptr_ff + QPTR_BITS'(1)) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + QCNT_BITS'(1);
      end else if (pop && !push) begin
         count_in = count_ff - QCNT_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

/* hw/rtl/lsr_back.sv */
// Back end: Bresenham stepping, clipping test, address multiply and output register.
module lsr_back import lsr_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   head_valid,
   input  cmd_type                head_cmd,
   output logic                   pop,
   input  logic [PITCH_BITS-1:0]  row_pitch,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output rsp_data_type           rsp_data
);

   typedef struct packed {
      logic [COORD_BITS-1:0]  x;
      logic [COORD_BITS-1:0]  y;
      logic                   last;
   } pix_type;

   // Stepping state.
   logic [COORD_BITS-1:0]  cur_major_ff, cur_major_in;
   logic [COORD_BITS-1:0]  cur_minor_ff, cur_minor_in;
   logic [ERR_BITS-1:0]    error_term_ff, error_term_in;
   logic [INC_S_BITS-1:0]  inc_straight_ff, inc_straight_in;
   logic [ERR_BITS-1:0]    inc_diagonal_ff, inc_diagonal_in;
   logic [DELTA_BITS-1:0]  pixels_left_ff, pixels_left_in;
   logic                   major_step_neg_ff, major_step_neg_in;
   logic                   minor_step_neg_ff, minor_step_neg_in;
   logic                   major_is_x_ff, major_is_x_in;

   logic                   pix_valid_ff, pix_valid_in;
   pix_type                pix_ff, pix_in;
   logic                   out_valid_ff;
   rsp_data_type           out_ff, out_in;

   logic                   out_ready, pix_ready, emit;
   logic                   err_pos;
   logic [COORD_BITS-1:0]  minor_next;
   logic [ERR_BITS-1:0]    err_next;
   logic                   x_ok, y_ok;
   logic [ADDR_BITS:0]     addr_sum;

   assign out_ready = !out_valid_ff || !rsp_stall;
   assign pix_ready = !pix_valid_ff || out_ready;
   assign pop       = head_valid && pix_ready;
   assign emit      = pop && !head_cmd.is_load && (pixels_left_ff != '0);

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;

   always_comb begin
      err_pos  = !error_term_ff[ERR_BITS-1] && (error_term_ff != '0);
      minor_next = cur_minor_ff;
      err_next   = error_term_ff + {1'b0, inc_straight_ff};
      if (err_pos) begin
         // Diagonal move: the minor coordinate steps before the pixel is formed.
         minor_next = minor_step_neg_ff ? (cur_minor_ff - COORD_BITS'(1))
                                        : (cur_minor_ff + COORD_BITS'(1));
         err_next   = error_term_ff + inc_diagonal_ff;
      end

      cur_major_in      = cur_major_ff;
      cur_minor_in      = cur_minor_ff;
      error_term_in     = error_term_ff;
      inc_straight_in   = inc_straight_ff;
      inc_diagonal_in   = inc_diagonal_ff;
      pixels_left_in    = pixels_left_ff;
      major_step_neg_in = major_step_neg_ff;
      minor_step_neg_in = minor_step_neg_ff;
      major_is_x_in     = major_is_x_ff;

      if (pop && head_cmd.is_load) begin
         cur_major_in      = head_cmd.cur_major;
         cur_minor_in      = head_cmd.cur_minor;
         error_term_in     = head_cmd.error_term;
         inc_straight_in   = head_cmd.inc_straight;
         inc_diagonal_in   = head_cmd.inc_diagonal;
         pixels_left_in    = head_cmd.pixels_left;
         major_step_neg_in = head_cmd.major_step_neg;
         minor_step_neg_in = head_cmd.minor_step_neg;
         major_is_x_in     = head_cmd.major_is_x;
      end else if (emit) begin
         cur_major_in   = major_step_neg_ff ? (cur_major_ff - COORD_BITS'(1))
                                            : (cur_major_ff + COORD_BITS'(1));
         cur_minor_in   = minor_next;
         error_term_in  = err_next;
         pixels_left_in = pixels_left_ff - DELTA_BITS'(1);
      end

      pix_in.x    = major_is_x_ff ? cur_major_ff : minor_next;
      pix_in.y    = major_is_x_ff ? minor_next : cur_major_ff;
      pix_in.last = (pixels_left_ff == DELTA_BITS'(1));
      pix_valid_in = pix_ready ? emit : pix_valid_ff;
   end

   // Clipping test and word address of the pixel in the stage register.
   always_comb begin
      x_ok = !pix_ff.x[COORD_BITS-1] && (pix_ff.x < COORD_BITS'(IMG_WIDTH));
      y_ok = !pix_ff.y[COORD_BITS-1] && (pix_ff.y < COORD_BITS'(IMG_HEIGHT));
      addr_sum = (ADDR_BITS+1)'(row_pitch) * (ADDR_BITS+1)'(pix_ff.y[Y_BITS-1:0])
               + (ADDR_BITS+1)'(pix_ff.x);
      out_in.pixel_x      = pix_ff.x;
      out_in.pixel_y      = pix_ff.y;
      out_in.pixel_inside = x_ok && y_ok;
      out_in.pixel_addr   = (x_ok && y_ok) ? addr_sum[ADDR_BITS-1:0] : '0;
      out_in.last_pixel   = pix_ff.last;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_major_ff      <= '0;
         cur_minor_ff      <= '0;
         error_term_ff     <= '0;
         inc_straight_ff   <= '0;
         inc_diagonal_ff   <= '0;
         pixels_left_ff    <= '0;
         major_step_neg_ff <= 1'b0;
         minor_step_neg_ff <= 1'b0;
         major_is_x_ff     <= 1'b1;
         pix_valid_ff      <= 1'b0;
         out_valid_ff      <= 1'b0;
      end else begin
         cur_major_ff      <= cur_major_in;
         cur_minor_ff      <= cur_minor_in;
         error_term_ff     <= error_term_in;
         inc_straight_ff   <= inc_straight_in;
         inc_diagonal_ff   <= inc_diagonal_in;
         pixels_left_ff    <= pixels_left_in;
         major_step_neg_ff <= major_step_neg_in;
         minor_step_neg_ff <= minor_step_neg_in;
         major_is_x_ff     <= major_is_x_in;
         pix_valid_ff      <= pix_valid_in;
         if (out_ready) begin
            out_valid_ff <= pix_valid_ff;
         end
      end
      if (emit) begin
         pix_ff <= pix_in;
      end
      if (out_ready && pix_valid_ff) begin
         out_ff <= out_in;
      end
   end

endmodule

/* hw/rtl/line_segment_rasterizer.sv */
// Bresenham line rasterizer top level: pitch register, front end, queue and back end.
// An advance beat passes the front stage register, the queue, the pixel stage register and the output register to rsp.
// Throughput is one beat per cycle while rsp is not stalled; the step loop in the back end sets it.
// Loads and advances on an idle segment are absorbed and produce no rsp beat.
// Synchronous active-high reset empties the pipeline and queue, idles the stepper
// and sets the row pitch to 1024 words.
module line_segment_rasterizer import lsr_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  req_data_type           req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output rsp_data_type           rsp_data,
   input  logic                   psel,
   input  logic                   penable,
   input  logic                   pwrite,
   input  logic [PADDR_BITS-1:0]  paddr,
   input  logic [PDATA_BITS-1:0]  pwdata,
   output logic [PDATA_BITS-1:0]  prdata,
   output logic                   pready
);

   logic [PITCH_BITS-1:0]  row_pitch_ff, row_pitch_in;
   logic                   push, queue_full, pop, head_valid;
   cmd_type                push_cmd, head_cmd;

   assign pready = 1'b1;

   always_comb begin
      row_pitch_in = row_pitch_ff;
      if (psel && penable && pwrite && (paddr[2] == REG_PITCH)) begin
         row_pitch_in = pwdata[PITCH_BITS-1:0];
      end
      prdata = (paddr[2] == REG_PITCH) ? PDATA_BITS'(row_pitch_ff) : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_pitch_ff <= PITCH_RESET;
      end else begin
         row_pitch_ff <= row_pitch_in;
      end
   end

   lsr_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_data   (req_data),
      .push       (push),
      .push_cmd   (push_cmd),
      .queue_full (queue_full)
   );

   lsr_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_cmd   (push_cmd),
      .full       (queue_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_cmd   (head_cmd)
   );

   lsr_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_cmd   (head_cmd),
      .pop        (pop),
      .row_pitch  (row_pitch_ff),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_data   (rsp_data)
   );

endmodule
